// File: rtl/core/lfr_pkg.sv
// Shared types, constants and helpers of the LCD fill-rectangle SPI engine.
`default_nettype none

package lfr_pkg;

  localparam int MAX_SIDE_DEF = 1024;

  localparam int SIDE_W     = 11;
  localparam int POS_W      = 10;
  localparam int ADDR_W     = 12;
  localparam int PIX_W      = 21;
  localparam int HP_W       = 8;
  localparam int OFF_W      = 8;
  localparam int COLOR_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int SETUP_W    = 4;
  localparam int BIT_W      = 3;

  localparam logic [PIX_W-1:0] PIXEL_SAT = {PIX_W{1'b1}};

  localparam logic [7:0] CMD_COLUMN = 8'h2A;
  localparam logic [7:0] CMD_ROW    = 8'h2B;
  localparam logic [7:0] CMD_WRITE  = 8'h2C;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_OFF      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD  = 3'd4;

  // Setup byte sequence, one frame each.
  localparam logic [SETUP_W-1:0] SB_COL_CMD   = 4'd1;
  localparam logic [SETUP_W-1:0] SB_COL_S_HI  = 4'd2;
  localparam logic [SETUP_W-1:0] SB_COL_S_LO  = 4'd3;
  localparam logic [SETUP_W-1:0] SB_COL_E_HI  = 4'd4;
  localparam logic [SETUP_W-1:0] SB_COL_E_LO  = 4'd5;
  localparam logic [SETUP_W-1:0] SB_ROW_CMD   = 4'd6;
  localparam logic [SETUP_W-1:0] SB_ROW_S_HI  = 4'd7;
  localparam logic [SETUP_W-1:0] SB_ROW_S_LO  = 4'd8;
  localparam logic [SETUP_W-1:0] SB_ROW_E_HI  = 4'd9;
  localparam logic [SETUP_W-1:0] SB_ROW_E_LO  = 4'd10;
  localparam logic [SETUP_W-1:0] SB_WRITE_CMD = 4'd11;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_SETUP  = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_DONE   = 4'b1000
  } lfr_phase_t;

  typedef struct packed {
    logic               req_type;
    logic [POS_W-1:0]   rect_x;
    logic [POS_W-1:0]   rect_y;
    logic [SIDE_W-1:0]  rect_w;
    logic [SIDE_W-1:0]  rect_h;
    logic [COLOR_W-1:0] fill_color;
  } lfr_in_t;

  typedef struct packed {
    logic sclk;
    logic mosi;
    logic dc_level;
    logic cs_n;
    logic busy_res;
    logic done_res;
    logic rejected;
  } lfr_out_t;

  function automatic logic [7:0] addr_hi(input logic [ADDR_W-1:0] a);
    addr_hi = 8'(a >> 8);
  endfunction

  function automatic logic [7:0] setup_byte(input logic [SETUP_W-1:0] idx,
                                            input logic [ADDR_W-1:0]  cs,
                                            input logic [ADDR_W-1:0]  ce,
                                            input logic [ADDR_W-1:0]  rs,
                                            input logic [ADDR_W-1:0]  re);
    logic [7:0] b;
    case (idx)
      SB_COL_CMD:  b = CMD_COLUMN;
      SB_COL_S_HI: b = addr_hi(cs);
      SB_COL_S_LO: b = cs[7:0];
      SB_COL_E_HI: b = addr_hi(ce);
      SB_COL_E_LO: b = ce[7:0];
      SB_ROW_CMD:  b = CMD_ROW;
      SB_ROW_S_HI: b = addr_hi(rs);
      SB_ROW_S_LO: b = rs[7:0];
      SB_ROW_E_HI: b = addr_hi(re);
      SB_ROW_E_LO: b = re[7:0];
      default:     b = CMD_WRITE;
    endcase
    setup_byte = b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/lcd_fill_rect_spi_engine.sv
// Top level of the LCD fill-rectangle engine: clipping, setup sequencer and SPI shifter.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------
//  in_      | input     | in_valid / in_ready   | lfr_in_t  (one tick + request)
//  out_     | output    | out_valid / out_ready | lfr_out_t (pin levels, flags)
//  cfg_     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Every input word is one tick of the serial engine; its result word is ready in the
// cycle after acceptance, and a new word is taken every cycle while the single result
// register is free or being taken. in_ready only drops while that register holds a
// word that is not taken. Reset is synchronous and loads the register defaults;
// no clearing pass. The clip product is registered on the tick after a request.
`default_nettype none

module lcd_fill_rect_spi_engine
  import lfr_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire lfr_in_t               in_item,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      lfr_out_t              out_item,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [SIDE_W-1:0] panel_width_r, panel_height_r;
  logic [OFF_W-1:0]  column_offset_r, row_offset_r;
  logic [HP_W-1:0]   half_period_r;

  // Engine state.
  lfr_phase_t        phase_r, phase_nxt;
  logic [SETUP_W-1:0] setup_idx_r, setup_idx_nxt;
  logic [BIT_W-1:0]  bit_index_r, bit_index_nxt;
  logic [HP_W-1:0]   tick_count_r, tick_count_nxt;
  logic [7:0]        shift_byte_r, shift_byte_nxt;
  logic [PIX_W-1:0]  pixels_left_r, pixels_left_nxt;
  logic              low_byte_next_r, low_byte_next_nxt;
  logic [ADDR_W-1:0] col_start_r, col_start_nxt, col_end_r, col_end_nxt;
  logic [ADDR_W-1:0] row_start_r, row_start_nxt, row_end_r, row_end_nxt;
  logic [COLOR_W-1:0] color_hold_r, color_hold_nxt;
  logic              frame_gap_r, frame_gap_nxt;
  logic              clock_high_r, clock_high_nxt;
  logic              load_pix_r, load_pix_nxt;
  logic [SIDE_W-1:0] clip_w_r, clip_w_nxt, clip_h_r, clip_h_nxt;

  logic              out_valid_r;
  lfr_out_t          out_item_r, out_nxt;

  logic              in_fire;
  logic [SIDE_W-1:0] pw, ph, cw, chh;
  logic [HP_W-1:0]   hp, tick_inc;
  logic              busy, sending, rej;
  logic [ADDR_W-1:0] x_ext, y_ext, x_end, y_end;
  logic [2*SIDE_W-1:0] pix_prod;
  logic [PIX_W-1:0]  pix_dec;
  logic [SETUP_W-1:0] setup_inc;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r   <= SIDE_W'(128);
      panel_height_r  <= SIDE_W'(160);
      column_offset_r <= '0;
      row_offset_r    <= '0;
      half_period_r   <= HP_W'(2);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PANEL_WIDTH:  panel_width_r   <= cfg_data;
        REG_PANEL_HEIGHT: panel_height_r  <= cfg_data;
        REG_COLUMN_OFF:   column_offset_r <= cfg_data[OFF_W-1:0];
        REG_ROW_OFF:      row_offset_r    <= cfg_data[OFF_W-1:0];
        REG_HALF_PERIOD:  half_period_r   <= cfg_data[HP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    setup_idx_nxt     = setup_idx_r;
    bit_index_nxt     = bit_index_r;
    tick_count_nxt    = tick_count_r;
    shift_byte_nxt    = shift_byte_r;
    pixels_left_nxt   = pixels_left_r;
    low_byte_next_nxt = low_byte_next_r;
    col_start_nxt     = col_start_r;
    col_end_nxt       = col_end_r;
    row_start_nxt     = row_start_r;
    row_end_nxt       = row_end_r;
    color_hold_nxt    = color_hold_r;
    frame_gap_nxt     = frame_gap_r;
    clock_high_nxt    = clock_high_r;
    load_pix_nxt      = load_pix_r;
    clip_w_nxt        = clip_w_r;
    clip_h_nxt        = clip_h_r;

    pw = (32'(panel_width_r) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : panel_width_r;
    ph = (32'(panel_height_r) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : panel_height_r;
    hp = (half_period_r == '0) ? HP_W'(1) : half_period_r;

    busy    = (phase_r != PH_IDLE);
    sending = busy && (phase_r != PH_DONE) && !frame_gap_r;

    out_nxt.sclk     = sending && clock_high_r;
    out_nxt.mosi     = sending && shift_byte_r[~bit_index_r];
    out_nxt.dc_level = !((phase_r == PH_SETUP) &&
                         (setup_idx_r == SB_COL_CMD || setup_idx_r == SB_ROW_CMD ||
                          setup_idx_r == SB_WRITE_CMD));
    out_nxt.cs_n     = !sending;
    out_nxt.busy_res = busy;
    out_nxt.done_res = (phase_r == PH_DONE);

    rej = in_item.req_type &&
          (in_item.rect_w == '0 || in_item.rect_h == '0 ||
           SIDE_W'(in_item.rect_x) >= pw || SIDE_W'(in_item.rect_y) >= ph || busy);
    out_nxt.rejected = rej;

    // Clipping: the sum is one bit wider than the panel size so it cannot wrap.
    x_ext = ADDR_W'(in_item.rect_x);
    y_ext = ADDR_W'(in_item.rect_y);
    x_end = x_ext + ADDR_W'(in_item.rect_w);
    y_end = y_ext + ADDR_W'(in_item.rect_h);
    cw    = (x_end > ADDR_W'(pw)) ? pw - SIDE_W'(in_item.rect_x) : in_item.rect_w;
    chh   = (y_end > ADDR_W'(ph)) ? ph - SIDE_W'(in_item.rect_y) : in_item.rect_h;

    pix_prod  = clip_w_r * clip_h_r;
    pix_dec   = (pixels_left_r == '0) ? '0 : pixels_left_r - PIX_W'(1);
    setup_inc = setup_idx_r + SETUP_W'(1);
    tick_inc  = tick_count_r + HP_W'(1);

    // The pixel count is needed only after the setup frames, so the product
    // of the registered clip sizes is loaded on the tick after the request.
    if (load_pix_r) begin
      pixels_left_nxt = (pix_prod > (2*SIDE_W)'(PIXEL_SAT)) ? PIXEL_SAT
                                                              : PIX_W'(pix_prod);
      load_pix_nxt    = 1'b0;
    end

    if (!busy) begin
      if (in_item.req_type && !rej) begin
        clip_w_nxt        = cw;
        clip_h_nxt        = chh;
        load_pix_nxt      = 1'b1;
        col_start_nxt     = x_ext + ADDR_W'(column_offset_r);
        col_end_nxt       = x_ext + ADDR_W'(column_offset_r) + ADDR_W'(cw) - ADDR_W'(1);
        row_start_nxt     = y_ext + ADDR_W'(row_offset_r);
        row_end_nxt       = y_ext + ADDR_W'(row_offset_r) + ADDR_W'(chh) - ADDR_W'(1);
        color_hold_nxt    = in_item.fill_color;
        low_byte_next_nxt = 1'b0;
        frame_gap_nxt     = 1'b0;
        phase_nxt         = PH_SETUP;
        setup_idx_nxt     = SB_COL_CMD;
        shift_byte_nxt    = CMD_COLUMN;
        bit_index_nxt     = '0;
        tick_count_nxt    = '0;
        clock_high_nxt    = 1'b0;
      end
    end else if (phase_r == PH_DONE) begin
      phase_nxt     = PH_IDLE;
      frame_gap_nxt = 1'b0;
    end else if (frame_gap_r) begin
      frame_gap_nxt  = 1'b0;
      bit_index_nxt  = '0;
      tick_count_nxt = '0;
      clock_high_nxt = 1'b0;
      if (setup_idx_r == SB_WRITE_CMD) begin
        phase_nxt         = PH_PIXELS;
        low_byte_next_nxt = 1'b0;
        shift_byte_nxt    = color_hold_r[COLOR_W-1 -: 8];
      end else begin
        setup_idx_nxt  = setup_inc;
        shift_byte_nxt = setup_byte(setup_inc, col_start_r, col_end_r,
                                    row_start_r, row_end_r);
      end
    end else begin
      tick_count_nxt = tick_inc;
      if (tick_inc >= hp) begin
        tick_count_nxt = '0;
        if (!clock_high_r) begin
          clock_high_nxt = 1'b1;
        end else begin
          clock_high_nxt = 1'b0;
          if (bit_index_r != '1) begin
            bit_index_nxt = bit_index_r + BIT_W'(1);
          end else if (phase_r != PH_PIXELS) begin
            bit_index_nxt = '0;
            frame_gap_nxt = 1'b1;
          end else if (!low_byte_next_r) begin
            low_byte_next_nxt = 1'b1;
            shift_byte_nxt    = color_hold_r[7:0];
            bit_index_nxt     = '0;
          end else begin
            low_byte_next_nxt = 1'b0;
            pixels_left_nxt   = pix_dec;
            bit_index_nxt     = '0;
            if (pix_dec == '0) begin
              phase_nxt = PH_DONE;
            end else begin
              shift_byte_nxt = color_hold_r[COLOR_W-1 -: 8];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      setup_idx_r     <= '0;
      bit_index_r     <= '0;
      tick_count_r    <= '0;
      shift_byte_r    <= '0;
      pixels_left_r   <= '0;
      low_byte_next_r <= 1'b0;
      col_start_r     <= '0;
      col_end_r       <= '0;
      row_start_r     <= '0;
      row_end_r       <= '0;
      color_hold_r    <= '0;
      frame_gap_r     <= 1'b0;
      clock_high_r    <= 1'b0;
      load_pix_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r         <= phase_nxt;
        setup_idx_r     <= setup_idx_nxt;
        bit_index_r     <= bit_index_nxt;
        tick_count_r    <= tick_count_nxt;
        shift_byte_r    <= shift_byte_nxt;
        pixels_left_r   <= pixels_left_nxt;
        low_byte_next_r <= low_byte_next_nxt;
        col_start_r     <= col_start_nxt;
        col_end_r       <= col_end_nxt;
        row_start_r     <= row_start_nxt;
        row_end_r       <= row_end_nxt;
        color_hold_r    <= color_hold_nxt;
        frame_gap_r     <= frame_gap_nxt;
        clock_high_r    <= clock_high_nxt;
        load_pix_r      <= load_pix_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item_r <= out_nxt;
      clip_w_r   <= clip_w_nxt;
      clip_h_r   <= clip_h_nxt;
    end
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == PH_DONE) |=> (phase_r == PH_IDLE))
    else $error("engine did not return to idle after the done tick");

  a_busy_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_item.req_type && phase_r != PH_IDLE) |=>
      (out_valid_r && out_item_r.rejected))
    else $error("request taken while busy was not rejected");

  a_setup_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SETUP) |-> (setup_idx_r >= SB_COL_CMD && setup_idx_r <= SB_WRITE_CMD))
    else $error("setup byte index out of range");

  a_no_load_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load_pix_r |-> (phase_r == PH_SETUP && setup_idx_r == SB_COL_CMD))
    else $error("pixel count load pending outside the first setup frame");

endmodule

`default_nettype wire
